/* hw/rtl/decimal_int_list_validator_assert.svh */
// Assertion macros for the decimal integer list validator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DECIMAL_INT_LIST_VALIDATOR_ASSERT_SVH
`define DECIMAL_INT_LIST_VALIDATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DILV_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define DILV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dilv_pkg.sv */
// Shared types and constants of the decimal integer list validator.
// No dependencies; every RTL module of the block imports this package.
package dilv_pkg;

    // Size of the value table and the widths that follow from it.
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Job queue between the parser and the table search.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Magnitude accumulator and its limits.
    localparam int MAG_W = 33;
    localparam logic [MAG_W-1:0] MAG_POS_LIMIT = 33'd2147483647;
    localparam logic [MAG_W-1:0] MAG_NEG_LIMIT = 33'd2147483648;
    localparam logic [MAG_W-1:0] MAG_SAT       = 33'd2147483649;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Argument status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOT_NUM   = 3'd1;
    localparam t_status ST_RANGE     = 3'd2;
    localparam t_status ST_DUPLICATE = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_arg;
    } t_char_in;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            arg_status;
        logic               list_done;
        logic               list_valid;
    } t_result;

    // One finished argument as the parser classified it. A pre_status of
    // ST_OK marks a candidate that still needs the duplicate search.
    typedef struct packed {
        logic signed [31:0] value;
        t_status            pre_status;
        logic               fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

/* hw/rtl/decimal_int_list_validator.sv */
// Top level of the decimal integer list validator.
// Depends on dilv_pkg, dilv_front, dilv_queue and dilv_back.
//
// Channel     Direction  Handshake                   Payload
// characters  in         push, full (accept: push & !full)   i_item   (t_char_in)
// results     out        empty, pop (accept: pop & !empty)   o_result (t_result)
//
// Every character transaction is taken while the job queue has room.
// A terminator whose argument is a well-formed value costs the back end a search
// of the value table, one read per cycle, that stops early on a match;
// a rejected argument skips the search and goes straight to the result.
// Reset is synchronous and active low; the table needs no clearing pass, since only
// entries below the fill count are read.
// full rises only when the four-entry job queue is full; a waiting result stalls the
// back end alone, and characters keep flowing until the queue fills.
module decimal_int_list_validator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dilv_pkg::t_char_in i_item,
    output logic               empty,
    input  logic               pop,
    output dilv_pkg::t_result  o_result
);
    import dilv_pkg::*;

    // Jobs pass from the parser to the search through the queue; the full
    // and empty flags travel together as one struct to both sides.
    logic     job_push;
    logic     job_pop;
    t_job     job_in;
    t_job     job_out;
    t_q_flags q_flags;

    // The front end parses one argument at a time and, on the terminator,
    // hands over its value together with the syntax and range verdict.
    dilv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_q_flags  (q_flags)
    );

    dilv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_flags (q_flags)
    );

    // The back end searches the table for duplicates, settles the status,
    // stores accepted values and holds the result until it is popped.
    dilv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_flags (q_flags),
        .o_job_pop (job_pop),
        .i_job     (job_out),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

/* hw/rtl/dilv_front.sv */
// Front end: accepts characters, parses one argument and classifies it.
// Depends on dilv_pkg; feeds finished arguments into dilv_queue.
module dilv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dilv_pkg::t_char_in i_item,
    output logic              o_full,
    output logic              o_job_push,
    output dilv_pkg::t_job    o_job,
    input  dilv_pkg::t_q_flags i_q_flags
);
    import dilv_pkg::*;

    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_SIGN  = 2'd1;
    localparam logic [1:0] POS_BODY  = 2'd2;

    logic [1:0]       r_pos, n_pos;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_bad, n_bad;
    logic             r_over, n_over;

    logic             accept;
    logic             is_digit;
    logic [MAG_W+2:0] mag_x10;
    logic [MAG_W-1:0] limit;
    logic [31:0]      mag_low;

    assign accept   = i_push && !i_q_flags.full;
    assign is_digit = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);
    // Times ten as (8 + 2), plus the digit held in the low nibble.
    assign mag_x10  = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0}
                    + {{(MAG_W - 1){1'b0}}, i_item.ch[3:0]};
    assign limit    = r_neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    assign mag_low  = r_mag[31:0];
    assign o_full   = i_q_flags.full;

    always_comb begin
        n_pos      = r_pos;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_bad      = r_bad;
        n_over     = r_over;
        o_job_push = 1'b0;
        o_job.fin  = i_item.final_arg;
        o_job.value = r_neg ? (32'd0 - mag_low) : mag_low;
        if (r_bad || (r_pos != POS_BODY)) begin
            o_job.pre_status = ST_NOT_NUM;
        end else if (r_over || (r_mag > limit)) begin
            o_job.pre_status = ST_RANGE;
        end else begin
            o_job.pre_status = ST_OK;
        end
        if (accept) begin
            if (i_item.ch == CH_NUL) begin
                o_job_push = 1'b1;
                n_pos      = POS_START;
                n_neg      = 1'b0;
                n_mag      = '0;
                n_bad      = 1'b0;
                n_over     = 1'b0;
            end else if (is_digit) begin
                n_pos = POS_BODY;
                if (mag_x10 > {3'b000, MAG_SAT}) begin
                    n_mag  = MAG_SAT;
                    n_over = 1'b1;
                end else begin
                    n_mag = mag_x10[MAG_W-1:0];
                end
            end else if ((r_pos == POS_START)
                         && ((i_item.ch == CH_PLUS) || (i_item.ch == CH_MINUS))) begin
                n_neg = (i_item.ch == CH_MINUS);
                n_pos = POS_SIGN;
            end else begin
                n_bad = 1'b1;
                n_pos = POS_BODY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_START;
            r_neg  <= 1'b0;
            r_mag  <= '0;
            r_bad  <= 1'b0;
            r_over <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_neg  <= n_neg;
            r_mag  <= n_mag;
            r_bad  <= n_bad;
            r_over <= n_over;
        end
    end

endmodule

/* hw/rtl/dilv_queue.sv */
// Short queue of classified arguments between the front and back ends.
// Depends on dilv_pkg for the job type and the queue depth.
module dilv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dilv_pkg::t_job     i_data,
    input  logic               i_pop,
    output dilv_pkg::t_job     o_data,
    output dilv_pkg::t_q_flags o_flags
);
    import dilv_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_flags.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_data        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/dilv_back.sv */
// Back end: duplicate search over the value table, final status, result slot.
// Depends on dilv_pkg and the assertion macro header.
module dilv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dilv_pkg::t_q_flags i_q_flags,
    output logic               o_job_pop,
    input  dilv_pkg::t_job     i_job,
    input  logic               i_pop,
    output logic               o_empty,
    output dilv_pkg::t_result  o_result
);
    import dilv_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [31:0]      r_table [MAX_ENTRIES];
    logic [31:0]      r_rd_data;

    logic [1:0]       r_state, n_state;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_list_error, n_list_error;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             slot_free;
    logic             issue;
    logic             hit_now;
    logic             rd_en;
    logic             wr_en;
    t_status          status;

    assign slot_free = !r_out_valid || i_pop;
    assign issue     = (r_idx < r_count);
    assign hit_now   = r_pend && (r_rd_data == r_job.value);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        if (r_job.pre_status != ST_OK) begin
            status = r_job.pre_status;
        end else if (r_hit) begin
            status = ST_DUPLICATE;
        end else if (r_count >= CNT_W'(MAX_ENTRIES)) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_hit        = r_hit;
        n_count      = r_count;
        n_list_error = r_list_error;
        n_out_valid  = r_out_valid && !i_pop;
        n_out        = r_out;
        o_job_pop    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_flags.empty && slot_free) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = (i_job.pre_status == ST_OK) ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH: begin
                // One table read issued per cycle, compared in the cycle after it.
                if (hit_now) begin
                    n_hit   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end else if (!issue && !r_pend) begin
                    n_state = S_FINISH;
                end else begin
                    rd_en  = issue;
                    n_pend = issue;
                    if (issue) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                wr_en                = (status == ST_OK);
                n_out.value          = (status == ST_OK) ? r_job.value : 32'sd0;
                n_out.arg_status     = status;
                n_out.list_done      = r_job.fin;
                n_out.list_valid     = !r_list_error && (status == ST_OK);
                n_out_valid          = 1'b1;
                n_state              = S_IDLE;
                if (status == ST_OK) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_list_error = 1'b1;
                end
                if (r_job.fin) begin
                    n_count      = '0;
                    n_list_error = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_count[IDX_W-1:0]] <= r_job.value;
        end
        if (rd_en) begin
            r_rd_data <= r_table[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_count      <= '0;
            r_list_error <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_count      <= n_count;
            r_list_error <= n_list_error;
            r_out_valid  <= n_out_valid;
        end
    end

`include "decimal_int_list_validator_assert.svh"

    `DILV_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_ENTRIES), "entry count beyond table size")
    `DILV_ASSERT(a_slot_free, (r_state != S_FINISH) || !r_out_valid, "result slot overwritten")
    `DILV_ASSERT(a_search_idx, (r_state != S_SEARCH) || (r_idx <= r_count), "search past count")
    `DILV_ASSERT_NEXT(a_list_clear, (r_state == S_FINISH) && r_job.fin,
                      (r_count == '0) && !r_list_error, "list state not cleared")

endmodule
